>>> src/htp_pkg.sv
// ----------------------------------------------------------------------------
// htp_pkg
// shared codes, hash constants and controller/datapath interface types
// ----------------------------------------------------------------------------
package htp_pkg;

    // operation codes
    localparam logic [1:0] FN_INSERT = 2'd0;
    localparam logic [1:0] FN_LOOKUP = 2'd1;
    localparam logic [1:0] FN_DELETE = 2'd2;

    // slot states
    localparam logic [1:0] SLOT_EMPTY   = 2'd0;
    localparam logic [1:0] SLOT_DELETED = 2'd1;
    localparam logic [1:0] SLOT_USED    = 2'd2;

    // result codes
    localparam logic [1:0] RES_HIT  = 2'd0;
    localparam logic [1:0] RES_NEW  = 2'd1;
    localparam logic [1:0] RES_MISS = 2'd2;
    localparam logic [1:0] RES_FULL = 2'd3;

    // murmur2 mixing, seed 0, length 4
    localparam logic [31:0] MIX_M   = 32'h5bd1e995;
    localparam logic [31:0] H_INIT  = 32'h6f47a654;   // 4 * MIX_M, low 32 bits
    localparam int          SHIFT_K = 24;
    localparam int          SHIFT_A = 13;
    localparam int          SHIFT_B = 15;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;

    // controller to datapath
    typedef struct packed {
        logic       clr_wr;
        logic       item_ld;
        logic       mul1;
        logic       mul2;
        logic       mul3;
        logic       home_ld;
        logic       rd_en;
        logic       adv;
        logic       wr_ins;
        logic       wr_del;
        logic       occ_inc;
        logic       occ_dec;
        logic       res_ld;
        logic [1:0] res_status;
        logic       res_hit_val;
        logic       out_ld;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       clr_last;
        logic [1:0] func;
        logic       occ_full;
        logic       slot_empty;
        logic       slot_used;
        logic       key_eq;
        logic       wrap;
        logic       out_free;
    } sts_t;

endpackage

>>> src/htp_ram.sv
// ----------------------------------------------------------------------------
// htp_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
module htp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/htp_dp.sv
// ----------------------------------------------------------------------------
// htp_dp
// datapath: item registers, hash stages, probe walk, slot memory, result regs
// ----------------------------------------------------------------------------
module htp_dp
    import htp_pkg::*;
#(
    parameter int CAPACITY   = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic [63:0] s_tdata,
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic [1:0]  m_tuser
);

    localparam int AW = $clog2(CAPACITY);
    localparam int EW = 2 + KEY_W + DATA_WIDTH;

    logic [1:0]       func_reg;
    logic [31:0]      key_reg;
    logic [31:0]      wval_reg;
    logic [31:0]      k1_reg;
    logic [31:0]      k2_reg;
    logic [31:0]      h3_reg;
    logic [AW-1:0]    idx_reg;
    logic [AW-1:0]    home_reg;
    logic [AW-1:0]    step_reg;
    logic [AW:0]      occ_reg;
    logic [AW-1:0]    clr_cnt_reg;
    logic [1:0]       res_status_reg;
    logic [31:0]      res_val_reg;
    logic [1:0]       out_status_reg;
    logic [31:0]      out_val_reg;
    logic             out_valid_reg;

    logic [31:0]      k1_mix;
    logic [31:0]      h_pre;
    logic [31:0]      h_mix;
    logic [31:0]      h_fin;
    logic [AW-1:0]    idx_next;
    logic [63:0]      wval_wide;
    logic [63:0]      rval_wide;
    logic [DATA_WIDTH-1:0] rd_val;
    logic [KEY_W-1:0] rd_key;
    logic [1:0]       rd_st;
    logic [EW-1:0]    rd_data;
    logic [EW-1:0]    wr_data;
    logic [AW-1:0]    wr_addr;
    logic             wr_en;

    // hash mixing between the multiplier stages
    assign k1_mix = k1_reg ^ (k1_reg >> SHIFT_K);
    assign h_pre  = H_INIT ^ k2_reg;
    assign h_mix  = h_pre ^ (h_pre >> SHIFT_A);
    assign h_fin  = h3_reg ^ (h3_reg >> SHIFT_B);

    assign idx_next = idx_reg + step_reg;

    assign {rd_val, rd_key, rd_st} = rd_data;
    assign wval_wide = {32'd0, wval_reg};
    assign rval_wide = 64'(rd_val);

    always_comb
    begin
        wr_en   = cmd.clr_wr | cmd.wr_ins | cmd.wr_del;
        wr_addr = cmd.clr_wr ? clr_cnt_reg : idx_reg;
        priority if (cmd.clr_wr)
        begin
            wr_data = '0;
        end
        else if (cmd.wr_del)
        begin
            wr_data = {rd_val, rd_key, SLOT_DELETED};
        end
        else
        begin
            wr_data = {wval_wide[DATA_WIDTH-1:0], key_reg, SLOT_USED};
        end
    end

    htp_ram #(
        .WIDTH(EW),
        .DEPTH(CAPACITY)
    ) u_slots (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (cmd.rd_en),
        .rd_addr(idx_reg),
        .rd_data(rd_data)
    );

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.item_ld)
        begin
            func_reg <= s_tuser;
            key_reg  <= s_tdata[31:0];
            wval_reg <= s_tdata[63:32];
        end
        if (cmd.mul1)
        begin
            k1_reg <= key_reg * MIX_M;
        end
        if (cmd.mul2)
        begin
            k2_reg <= k1_mix * MIX_M;
        end
        if (cmd.mul3)
        begin
            h3_reg <= h_mix * MIX_M;
        end
        if (cmd.home_ld)
        begin
            idx_reg  <= h_fin[AW-1:0];
            home_reg <= h_fin[AW-1:0];
            step_reg <= AW'(1);
        end
        else if (cmd.adv)
        begin
            idx_reg  <= idx_next;
            step_reg <= step_reg + AW'(1);
        end
        if (cmd.res_ld)
        begin
            res_status_reg <= cmd.res_status;
            res_val_reg    <= cmd.res_hit_val ? rval_wide[31:0] : 32'd0;
        end
        if (cmd.out_ld)
        begin
            out_status_reg <= res_status_reg;
            out_val_reg    <= res_val_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.occ_inc)
            begin
                occ_reg <= occ_reg + (AW+1)'(1);
            end
            else if (cmd.occ_dec && occ_reg != '0)
            begin
                occ_reg <= occ_reg - (AW+1)'(1);
            end
            if (cmd.out_ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sts.clr_last   = (clr_cnt_reg == AW'(CAPACITY - 1));
        sts.func       = func_reg;
        sts.occ_full   = (occ_reg >= (AW+1)'(CAPACITY));
        sts.slot_empty = (rd_st == SLOT_EMPTY);
        sts.slot_used  = (rd_st == SLOT_USED);
        sts.key_eq     = (rd_key == key_reg);
        sts.wrap       = (idx_next == home_reg);
        sts.out_free   = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_val_reg;
    assign m_tuser  = out_status_reg;

endmodule

>>> src/htp_ctrl.sv
// ----------------------------------------------------------------------------
// htp_ctrl
// controller: clearing pass, hash sequencing, probe loop and result handoff
// ----------------------------------------------------------------------------
module htp_ctrl
    import htp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_HOME,
        S_READ,
        S_CHECK,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   is_insert;
    logic   is_delete;
    logic   is_search;

    assign is_insert = (sts.func == FN_INSERT);
    assign is_delete = (sts.func == FN_DELETE);
    assign is_search = (sts.func == FN_LOOKUP) || is_delete;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.item_ld = 1'b1;
                    state_next  = S_MUL1;
                end
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_MUL3;
            end
            S_MUL3:
            begin
                cmd.mul3   = 1'b1;
                state_next = S_HOME;
            end
            S_HOME:
            begin
                cmd.home_ld = 1'b1;
                if (is_insert && sts.occ_full)
                begin
                    cmd.res_ld     = 1'b1;
                    cmd.res_status = RES_FULL;
                    state_next     = S_OUT;
                end
                else if (!is_insert && !is_search)
                begin
                    cmd.res_ld     = 1'b1;
                    cmd.res_status = RES_MISS;
                    state_next     = S_OUT;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (is_insert)
                begin
                    if (sts.slot_used && sts.key_eq)
                    begin
                        // update in place
                        cmd.wr_ins     = 1'b1;
                        cmd.res_ld     = 1'b1;
                        cmd.res_status = RES_HIT;
                        state_next     = S_OUT;
                    end
                    else if (!sts.slot_used)
                    begin
                        cmd.wr_ins     = 1'b1;
                        cmd.occ_inc    = 1'b1;
                        cmd.res_ld     = 1'b1;
                        cmd.res_status = RES_NEW;
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        cmd.adv = 1'b1;
                        if (sts.wrap)
                        begin
                            cmd.res_ld     = 1'b1;
                            cmd.res_status = RES_FULL;
                            state_next     = S_OUT;
                        end
                        else
                        begin
                            state_next = S_READ;
                        end
                    end
                end
                else
                begin
                    if (sts.slot_empty)
                    begin
                        cmd.res_ld     = 1'b1;
                        cmd.res_status = RES_MISS;
                        state_next     = S_OUT;
                    end
                    else if (sts.slot_used && sts.key_eq)
                    begin
                        cmd.res_ld      = 1'b1;
                        cmd.res_status  = RES_HIT;
                        cmd.res_hit_val = 1'b1;
                        cmd.wr_del      = is_delete;
                        cmd.occ_dec     = is_delete;
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        cmd.adv = 1'b1;
                        if (sts.wrap)
                        begin
                            cmd.res_ld     = 1'b1;
                            cmd.res_status = RES_MISS;
                            state_next     = S_OUT;
                        end
                        else
                        begin
                            state_next = S_READ;
                        end
                    end
                end
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_ld = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

>>> src/hash_table_triangular_probe.sv
// ----------------------------------------------------------------------------
// hash_table_triangular_probe
// open-addressing hash table, murmur2 home slot, triangular probe walk
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tdata {write_value, key_digest}, tuser func
//  m_*       out  m_tvalid/m_tready  tdata read_value, tuser status
//
//  sequence: one request at a time; accept, 3 hash multiplier steps, home
//    step, then a memory read and a compare per probed slot, and a handoff
//  the probe loop through the slot memory, with its one read port, sets the rate
//  reset: a clearing pass writes every slot empty, with s_tready low throughout
//  stalls: a result sits in the output register while the next request is
//    accepted and hashed; the following result waits until that one is taken
//
module hash_table_triangular_probe
    import htp_pkg::*;
#(
    parameter int CAPACITY   = 256,   // power of two
    parameter int DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // key_digest[31:0], write_value[63:32]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // read_value[31:0]
    output logic [1:0]  m_tuser    // status[1:0]
);

    cmd_t cmd;   // controller commands
    sts_t sts;   // datapath status

    // sequencing of the clear, hash and probe steps
    htp_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // hash pipeline registers, slot memory, occupancy and output register
    htp_dp #(
        .CAPACITY  (CAPACITY),
        .DATA_WIDTH(DATA_WIDTH)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .sts     (sts),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule

>>> src/htp_check.sv
// ----------------------------------------------------------------------------
// htp_check
// port-level assertions for the hash table, bound to the top level
// ----------------------------------------------------------------------------
module htp_check
    import htp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [63:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one request in flight at a time
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    // read value only on a hit
    a_zero_val: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != RES_HIT |-> m_tdata == 32'd0)
        else $error("nonzero read value without hit");

    // a new result is only raised at the end of a busy period
    a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result raised while idle");

endmodule

bind hash_table_triangular_probe htp_check u_check (.*);
